>>> rtl/tcw_pkg.sv
`timescale 1ns / 1ps

package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int COPY_COUNT = COLUMNS * (ROWS - 1);
  localparam int ADDR_W     = $clog2(CELL_COUNT);

  // Field widths
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 8;
  localparam int CELL_W  = CHAR_W + COLOR_W;
  localparam int CMD_W   = 2;

  // Queue between the front and the back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // Character codes and colors
  localparam logic [CHAR_W-1:0]  CH_NEWLINE  = 8'd10;
  localparam logic [CHAR_W-1:0]  CH_RETURN   = 8'd13;
  localparam logic [CHAR_W-1:0]  CH_SPACE    = 8'd32;
  localparam logic [COLOR_W-1:0] RESET_COLOR = 8'd7;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT_CHAR = 2'd0,
    CMD_PUT_CELL = 2'd1,
    CMD_CLEAR    = 2'd2,
    CMD_READ     = 2'd3
  } tcw_cmd_e;

  typedef enum logic [2:0] {
    OP_CHAR,
    OP_NEWLINE,
    OP_RETURN,
    OP_PUT,
    OP_READ,
    OP_CLEAR,
    OP_OFFSCREEN
  } tcw_op_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_READ,
    S_COPY,
    S_BLANK,
    S_FILL
  } tcw_state_e;

  typedef struct packed {
    tcw_op_e              op;
    logic [CHAR_W-1:0]    char_code;
    logic [COLOR_W-1:0]   color;
    logic [ADDR_W-1:0]    addr;
  } tcw_item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } tcw_q_status_t;

endpackage

>>> rtl/text_console_cell_writer.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake               Payload
// input     in         in_valid_i/in_stall_o   command, char_code, cell_color, column_x, row_y
// output    out        out_valid_o/out_stall_i cursor_row_out, cursor_column_out, cell_data,
//                                              out_of_range
// config    in         cfg_we_i                cfg_wdata_i (text_color)
//
// Items pass through a two-entry queue; the back end works on one item at a time, and the
// cell store has a single write port, so scrolling and clearing sweep it cell by cell.
// Put char, carriage return, put cell and off-screen items finish in the idle state; a read
// passes through the read state. A newline or line wrap on the last row scrolls: rows are
// copied up, then the last row is blanked. Clear fills the whole store with blanks.
// After reset the store is filled with blanks with in_stall_o high; configuration writes
// are taken during that time.

module text_console_cell_writer import tcw_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [COLOR_W-1:0]  cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [CMD_W-1:0]    command_i,
  input  logic [CHAR_W-1:0]   char_code_i,
  input  logic [COLOR_W-1:0]  cell_color_i,
  input  logic [COL_W-1:0]    column_x_i,
  input  logic [ROW_W-1:0]    row_y_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [ROW_W-1:0]    cursor_row_out_o,
  output logic [COL_W-1:0]    cursor_column_out_o,
  output logic [CELL_W-1:0]   cell_data_o,
  output logic                out_of_range_o
);

  logic [COLOR_W-1:0] text_color_q;
  logic               push, pop, init_busy;
  tcw_item_t          push_item, head_item;
  tcw_q_status_t      q_status;

  // Text color register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_color_q <= RESET_COLOR;
    end else if (cfg_we_i) begin
      text_color_q <= cfg_wdata_i;
    end
  end

  tcw_front u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .char_code_i  (char_code_i),
    .cell_color_i (cell_color_i),
    .column_x_i   (column_x_i),
    .row_y_i      (row_y_i),
    .q_status_i   (q_status),
    .init_busy_i  (init_busy),
    .push_o       (push),
    .item_o       (push_item)
  );

  tcw_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (push_item),
    .pop_i    (pop),
    .head_o   (head_item),
    .status_o (q_status)
  );

  tcw_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .text_color_i        (text_color_q),
    .head_i              (head_item),
    .q_status_i          (q_status),
    .pop_o               (pop),
    .init_busy_o         (init_busy),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .cursor_row_out_o    (cursor_row_out_o),
    .cursor_column_out_o (cursor_column_out_o),
    .cell_data_o         (cell_data_o),
    .out_of_range_o      (out_of_range_o)
  );

endmodule

>>> rtl/tcw_front.sv
`timescale 1ns / 1ps

module tcw_front import tcw_pkg::*; (
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [CMD_W-1:0]    command_i,
  input  logic [CHAR_W-1:0]   char_code_i,
  input  logic [COLOR_W-1:0]  cell_color_i,
  input  logic [COL_W-1:0]    column_x_i,
  input  logic [ROW_W-1:0]    row_y_i,
  input  tcw_q_status_t       q_status_i,
  input  logic                init_busy_i,
  output logic                push_o,
  output tcw_item_t           item_o
);

  logic on_screen;

  // Hold off new items while the queue is full or the store is being initialized
  assign in_stall_o = q_status_i.full || init_busy_i;
  assign push_o     = in_valid_i && !in_stall_o;

  assign on_screen = ({1'b0, column_x_i} < (COL_W + 1)'(COLUMNS)) &&
                     ({1'b0, row_y_i} < (ROW_W + 1)'(ROWS));

  // Classify the command into one back-end operation
  always_comb begin
    item_o.char_code = char_code_i;
    item_o.color     = cell_color_i;
    item_o.addr      = ADDR_W'(ADDR_W'(row_y_i) * ADDR_W'(COLUMNS)) + ADDR_W'(column_x_i);
    case (tcw_cmd_e'(command_i))
      CMD_PUT_CHAR: begin
        if (char_code_i == CH_NEWLINE) begin
          item_o.op = OP_NEWLINE;
        end else if (char_code_i == CH_RETURN) begin
          item_o.op = OP_RETURN;
        end else begin
          item_o.op = OP_CHAR;
        end
      end
      CMD_PUT_CELL: begin
        item_o.op = on_screen ? OP_PUT : OP_OFFSCREEN;
      end
      CMD_CLEAR: begin
        item_o.op = OP_CLEAR;
      end
      CMD_READ: begin
        item_o.op = on_screen ? OP_READ : OP_OFFSCREEN;
      end
      default: begin
        item_o.op = OP_OFFSCREEN;
      end
    endcase
  end

endmodule

>>> rtl/tcw_queue.sv
`timescale 1ns / 1ps

module tcw_queue import tcw_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tcw_item_t     item_i,
  input  logic          pop_i,
  output tcw_item_t     head_o,
  output tcw_q_status_t status_o
);

  tcw_item_t               entry_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [QUEUE_AW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CW-1:0]     count_q, count_d;

  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == QUEUE_CW'(QUEUE_DEPTH));
  assign head_o         = entry_q[rd_ptr_q];

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed item
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!status_o.full || pop_i))
    else $error("queue pushed while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !status_o.empty)
    else $error("queue popped while empty");

endmodule

>>> rtl/tcw_back.sv
`timescale 1ns / 1ps

module tcw_back import tcw_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [COLOR_W-1:0]  text_color_i,
  input  tcw_item_t           head_i,
  input  tcw_q_status_t       q_status_i,
  output logic                pop_o,
  output logic                init_busy_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [ROW_W-1:0]    cursor_row_out_o,
  output logic [COL_W-1:0]    cursor_column_out_o,
  output logic [CELL_W-1:0]   cell_data_o,
  output logic                out_of_range_o
);

  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] COPY_END  = ADDR_W'(COPY_COUNT);

  tcw_state_e            state_q, state_d;
  logic [ADDR_W-1:0]     sweep_q, sweep_d;
  logic [ROW_W-1:0]      row_q, row_d;
  logic [COL_W-1:0]      col_q, col_d;

  logic [CELL_W-1:0]     cell_mem_q [CELL_COUNT];
  logic [CELL_W-1:0]     rd_data_q;
  logic                  mem_we, mem_re;
  logic [ADDR_W-1:0]     mem_waddr, mem_raddr;
  logic [CELL_W-1:0]     mem_wdata;

  logic                  out_valid_q, out_valid_d;
  logic [ROW_W-1:0]      out_row_q, out_row_d;
  logic [COL_W-1:0]      out_col_q, out_col_d;
  logic [CELL_W-1:0]     out_data_q, out_data_d;
  logic                  out_oor_q, out_oor_d;

  logic                  out_free, load_out;
  logic                  col_last, row_last, sweep_last;
  logic [ADDR_W-1:0]     cur_addr;
  logic [CELL_W-1:0]     blank, res_data;
  logic                  res_oor;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign pop_o       = (state_q == S_IDLE) && !q_status_i.empty && out_free;
  assign init_busy_o = (state_q == S_INIT);
  assign col_last    = (col_q == COL_W'(COLUMNS - 1));
  assign row_last    = (row_q == ROW_W'(ROWS - 1));
  assign sweep_last  = (sweep_q == LAST_CELL);
  assign cur_addr    = ADDR_W'(ADDR_W'(row_q) * ADDR_W'(COLUMNS)) + ADDR_W'(col_q);
  assign blank       = {text_color_i, CH_SPACE};

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_INIT: begin
        if (sweep_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (pop_o) begin
          case (head_i.op)
            OP_CHAR:    if (col_last && row_last) state_d = S_COPY;
            OP_NEWLINE: if (row_last) state_d = S_COPY;
            OP_READ:    state_d = S_READ;
            OP_CLEAR:   state_d = S_FILL;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_READ: begin
        state_d = S_IDLE;
      end
      S_COPY: begin
        if (sweep_q == COPY_END) state_d = S_BLANK;
      end
      S_BLANK, S_FILL: begin
        if (sweep_last) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Memory port, sweep counter, cursor and result
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = sweep_q;
    mem_raddr = head_i.addr;
    mem_wdata = blank;
    sweep_d   = sweep_q;
    row_d     = row_q;
    col_d     = col_q;
    load_out  = 1'b0;
    res_data  = '0;
    res_oor   = 1'b0;
    case (state_q)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = {RESET_COLOR, CH_SPACE};
        sweep_d   = sweep_last ? '0 : sweep_q + 1'b1;
      end
      S_IDLE: begin
        if (pop_o) begin
          case (head_i.op)
            OP_CHAR: begin
              mem_we    = 1'b1;
              mem_waddr = cur_addr;
              mem_wdata = {text_color_i, head_i.char_code};
              if (col_last) begin
                col_d = '0;
                if (!row_last) begin
                  row_d    = row_q + 1'b1;
                  load_out = 1'b1;
                end
              end else begin
                col_d    = col_q + 1'b1;
                load_out = 1'b1;
              end
            end
            OP_NEWLINE: begin
              col_d = '0;
              if (!row_last) begin
                row_d    = row_q + 1'b1;
                load_out = 1'b1;
              end
            end
            OP_RETURN: begin
              col_d    = '0;
              load_out = 1'b1;
            end
            OP_PUT: begin
              mem_we    = 1'b1;
              mem_waddr = head_i.addr;
              mem_wdata = {head_i.color, head_i.char_code};
              load_out  = 1'b1;
            end
            OP_READ: begin
              mem_re = 1'b1;
            end
            OP_CLEAR: begin
              row_d = '0;
              col_d = '0;
            end
            default: begin
              res_oor  = 1'b1;
              load_out = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        res_data = rd_data_q;
        load_out = 1'b1;
      end
      S_COPY: begin
        // Read one row ahead, write the cell fetched in the cycle before
        mem_re    = (sweep_q != COPY_END);
        mem_raddr = sweep_q + ADDR_W'(COLUMNS);
        mem_we    = (sweep_q != '0);
        mem_waddr = sweep_q - 1'b1;
        mem_wdata = rd_data_q;
        if (sweep_q != COPY_END) sweep_d = sweep_q + 1'b1;
      end
      S_BLANK, S_FILL: begin
        mem_we = 1'b1;
        if (sweep_last) begin
          sweep_d  = '0;
          load_out = 1'b1;
        end else begin
          sweep_d = sweep_q + 1'b1;
        end
      end
      default: begin
        sweep_d = '0;
      end
    endcase
  end

  // Output register: load a finished result, hold it while stalled
  always_comb begin
    out_valid_d = load_out || (out_valid_q && out_stall_i);
    out_row_d   = load_out ? row_d    : out_row_q;
    out_col_d   = load_out ? col_d    : out_col_q;
    out_data_d  = load_out ? res_data : out_data_q;
    out_oor_d   = load_out ? res_oor  : out_oor_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      sweep_q     <= '0;
      row_q       <= '0;
      col_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      row_q       <= row_d;
      col_q       <= col_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_row_q  <= out_row_d;
    out_col_q  <= out_col_d;
    out_data_q <= out_data_d;
    out_oor_q  <= out_oor_d;
  end

  // Cell store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cell_mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_data_q <= cell_mem_q[mem_raddr];
    end
  end

  assign out_valid_o         = out_valid_q;
  assign cursor_row_out_o    = out_row_q;
  assign cursor_column_out_o = out_col_q;
  assign cell_data_o         = out_data_q;
  assign out_of_range_o      = out_oor_q;

  a_cursor_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, col_q} < (COL_W + 1)'(COLUMNS)) && ({1'b0, row_q} < (ROW_W + 1)'(ROWS)))
    else $error("cursor off screen");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> out_free)
    else $error("result overwrites an undelivered one");

  a_blank_on_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BLANK) |-> row_last)
    else $error("scroll blanking with cursor not on last row");

  a_init_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INIT) |-> (!out_valid_q && !pop_o))
    else $error("activity during store initialization");

endmodule

>>> dv/console_checker.sv
`timescale 1ns / 1ps

module console_checker import tcw_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [COLOR_W-1:0] cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [CMD_W-1:0]   command_i,
  input  logic [CHAR_W-1:0]  char_code_i,
  input  logic [COLOR_W-1:0] cell_color_i,
  input  logic [COL_W-1:0]   column_x_i,
  input  logic [ROW_W-1:0]   row_y_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [ROW_W-1:0]   cursor_row_out_i,
  input  logic [COL_W-1:0]   cursor_column_out_i,
  input  logic [CELL_W-1:0]  cell_data_i,
  input  logic               out_of_range_i,
  output int                 pending_o,
  output int                 fail_count_o
);

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  column;
    logic [CELL_W-1:0] cell_word;
    logic              off_screen;
  } console_status_t;

  // Shadow copy of the screen, cursor and typing color
  logic [CELL_W-1:0]  shadow_cells [CELL_COUNT];
  logic [ROW_W-1:0]   shadow_row;
  logic [COL_W-1:0]   shadow_col;
  logic [COLOR_W-1:0] typing_color;
  console_status_t    awaited_status [$];

  // Blank every cell in the given color
  function automatic void fill_screen(logic [COLOR_W-1:0] color);
    for (int i = 0; i < CELL_COUNT; i++) shadow_cells[i] = {color, CH_SPACE};
  endfunction

  // Move to the start of the next row; scroll the screen up at the bottom
  function automatic void next_row();
    shadow_col = '0;
    if (int'(shadow_row) < ROWS - 1) begin
      shadow_row = shadow_row + 1'b1;
    end else begin
      for (int i = 0; i < COPY_COUNT; i++) shadow_cells[i] = shadow_cells[i + COLUMNS];
      for (int i = COPY_COUNT; i < CELL_COUNT; i++) shadow_cells[i] = {typing_color, CH_SPACE};
      shadow_row = ROW_W'(ROWS - 1);
    end
  endfunction

  // Carry out one command on the shadow and return the status it reports
  function automatic console_status_t apply_command(tcw_cmd_e cmd, logic [CHAR_W-1:0] ch,
      logic [COLOR_W-1:0] color, logic [COL_W-1:0] x, logic [ROW_W-1:0] y);
    console_status_t st;
    logic            on_screen;
    int              addr;
    on_screen = (int'(x) < COLUMNS) && (int'(y) < ROWS);
    addr = int'(y) * COLUMNS + int'(x);
    st.cell_word = '0;
    st.off_screen = 1'b0;
    case (cmd)
      CMD_PUT_CHAR: begin
        if (ch == CH_NEWLINE) begin
          next_row();
        end else if (ch == CH_RETURN) begin
          shadow_col = '0;
        end else begin
          shadow_cells[int'(shadow_row) * COLUMNS + int'(shadow_col)] = {typing_color, ch};
          if (int'(shadow_col) == COLUMNS - 1) begin
            next_row();
          end else begin
            shadow_col = shadow_col + 1'b1;
          end
        end
      end
      CMD_PUT_CELL: begin
        if (on_screen) begin
          shadow_cells[addr] = {color, ch};
        end else begin
          st.off_screen = 1'b1;
        end
      end
      CMD_CLEAR: begin
        fill_screen(typing_color);
        shadow_row = '0;
        shadow_col = '0;
      end
      default: begin
        if (on_screen) begin
          st.cell_word = shadow_cells[addr];
        end else begin
          st.off_screen = 1'b1;
        end
      end
    endcase
    st.row = shadow_row;
    st.column = shadow_col;
    return st;
  endfunction

  // Count and report one differing field
  function automatic void check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      fail_count_o++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endfunction

  // Predict on each accepted item, compare each accepted result with the oldest one
  always @(posedge clk_i or negedge rst_ni) begin : watch_channels
    console_status_t want;
    if (!rst_ni) begin
      fill_screen(RESET_COLOR);
      shadow_row = '0;
      shadow_col = '0;
      typing_color = RESET_COLOR;
      awaited_status.delete();
      pending_o = 0;
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        typing_color = cfg_wdata_i;
      end
      if (in_valid_i && !in_stall_i) begin
        awaited_status.push_back(apply_command(tcw_cmd_e'(command_i), char_code_i,
                                               cell_color_i, column_x_i, row_y_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (awaited_status.size() == 0) begin
          fail_count_o++;
          $display("%0t: result with none awaited, row %0d column %0d cell %0h flag %0d",
                   $time, cursor_row_out_i, cursor_column_out_i, cell_data_i, out_of_range_i);
        end else begin
          want = awaited_status.pop_front();
          check_field("cursor row", 32'(want.row), 32'(cursor_row_out_i));
          check_field("cursor column", 32'(want.column), 32'(cursor_column_out_i));
          check_field("cell data", 32'(want.cell_word), 32'(cell_data_i));
          check_field("out of range", 32'(want.off_screen), 32'(out_of_range_i));
        end
      end
      pending_o = awaited_status.size();
    end
  end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import tcw_pkg::*;

  localparam int CYCLE_LIMIT     = 6_000_000;
  localparam int PHASE_ITEMS     = 175;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int TAIL_CYCLES     = 2100;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [COLOR_W-1:0] cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [CMD_W-1:0]   command = '0;
  logic [CHAR_W-1:0]  char_code = '0;
  logic [COLOR_W-1:0] cell_color = '0;
  logic [COL_W-1:0]   column_x = '0;
  logic [ROW_W-1:0]   row_y = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [ROW_W-1:0]   cursor_row;
  logic [COL_W-1:0]   cursor_column;
  logic [CELL_W-1:0]  cell_data;
  logic               out_of_range;
  int                 pending;
  int                 fail_count;
  int                 cycles = 0;
  int                 items_sent = 0;
  logic               gapless = 1'b0;
  logic               hold_off_req = 1'b0;
  logic               hold_off_done = 1'b0;

  text_console_cell_writer uut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_we_i            (cfg_we),
    .cfg_wdata_i         (cfg_wdata),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .command_i           (command),
    .char_code_i         (char_code),
    .cell_color_i        (cell_color),
    .column_x_i          (column_x),
    .row_y_i             (row_y),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .cursor_row_out_o    (cursor_row),
    .cursor_column_out_o (cursor_column),
    .cell_data_o         (cell_data),
    .out_of_range_o      (out_of_range)
  );

  console_checker console_watch (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_we_i            (cfg_we),
    .cfg_wdata_i         (cfg_wdata),
    .in_valid_i          (in_valid),
    .in_stall_i          (in_stall),
    .command_i           (command),
    .char_code_i         (char_code),
    .cell_color_i        (cell_color),
    .column_x_i          (column_x),
    .row_y_i             (row_y),
    .out_valid_i         (out_valid),
    .out_stall_i         (out_stall),
    .cursor_row_out_i    (cursor_row),
    .cursor_column_out_i (cursor_column),
    .cell_data_i         (cell_data),
    .out_of_range_i      (out_of_range),
    .pending_o           (pending),
    .fail_count_o        (fail_count)
  );

  always #10 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Idle cycles before an item: mostly none, some short, a few long
  function automatic int gap_len();
    int r;
    r = int'($urandom_range(0, 99));
    if (gapless || r < 65) return 0;
    if (r < 93) return int'($urandom_range(1, 3));
    return int'($urandom_range(10, 40));
  endfunction

  // Any byte that is typed as a character
  function automatic logic [CHAR_W-1:0] any_glyph();
    logic [CHAR_W-1:0] c;
    do c = CHAR_W'($urandom_range(0, 255)); while (c == CH_NEWLINE || c == CH_RETURN);
    return c;
  endfunction

  // Rows with the bottom and the top favored, where scrolling shows
  function automatic logic [ROW_W-1:0] pick_row();
    int r;
    r = int'($urandom_range(0, 9));
    if (r < 3) return ROW_W'(ROWS - 1);
    if (r < 4) return '0;
    return ROW_W'($urandom_range(0, ROWS - 1));
  endfunction

  // Offer one item and hold it until it is taken
  task automatic send_item(input tcw_cmd_e op, input logic [CHAR_W-1:0] ch,
      input logic [COLOR_W-1:0] color, input logic [COL_W-1:0] x, input logic [ROW_W-1:0] y);
    int gap;
    gap = gap_len();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    command    <= op;
    char_code  <= ch;
    cell_color <= color;
    column_x   <= x;
    row_y      <= y;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic type_char(input logic [CHAR_W-1:0] ch);
    send_item(CMD_PUT_CHAR, ch, COLOR_W'($urandom_range(0, 255)),
              COL_W'($urandom_range(0, 127)), ROW_W'($urandom_range(0, 31)));
  endtask

  task automatic put_cell(input logic [CHAR_W-1:0] ch, input logic [COLOR_W-1:0] color,
      input logic [COL_W-1:0] x, input logic [ROW_W-1:0] y);
    send_item(CMD_PUT_CELL, ch, color, x, y);
  endtask

  task automatic read_cell(input logic [COL_W-1:0] x, input logic [ROW_W-1:0] y);
    send_item(CMD_READ, CHAR_W'($urandom_range(0, 255)), COLOR_W'($urandom_range(0, 255)),
              x, y);
  endtask

  task automatic clear_screen();
    send_item(CMD_CLEAR, CHAR_W'($urandom_range(0, 255)), COLOR_W'($urandom_range(0, 255)),
              COL_W'($urandom_range(0, 127)), ROW_W'($urandom_range(0, 31)));
  endtask

  // Drop valid and wait until every awaited result has come
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_color(input logic [COLOR_W-1:0] c);
    cfg_we    <= 1'b1;
    cfg_wdata <= c;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // One random burst of console traffic
  task automatic run_sequence();
    int               kind;
    int               n;
    logic [COL_W-1:0] xs [8];
    logic [ROW_W-1:0] ys [8];
    kind = int'($urandom_range(0, 99));
    gapless = ($urandom_range(0, 3) == 0);
    if (kind < 30) begin
      // short line of text, usually ended
      n = int'($urandom_range(1, 20));
      repeat (n) type_char(any_glyph());
      n = int'($urandom_range(0, 9));
      if (n < 7) begin
        type_char(CH_NEWLINE);
      end else if (n < 9) begin
        type_char(CH_RETURN);
      end
    end else if (kind < 38) begin
      // about a full line of text, so the cursor often wraps at the line end
      repeat ($urandom_range(75, 85)) type_char(any_glyph());
    end else if (kind < 48) begin
      repeat ($urandom_range(3, 30)) type_char(CH_NEWLINE);
    end else if (kind < 63) begin
      // place cells, then read them back
      n = int'($urandom_range(1, 8));
      for (int i = 0; i < n; i++) begin
        xs[i] = COL_W'($urandom_range(0, COLUMNS - 1));
        ys[i] = pick_row();
        put_cell(CHAR_W'($urandom_range(0, 255)), COLOR_W'($urandom_range(0, 255)),
                 xs[i], ys[i]);
      end
      for (int i = 0; i < n; i++) read_cell(xs[i], ys[i]);
    end else if (kind < 78) begin
      repeat ($urandom_range(1, 6)) begin
        read_cell(COL_W'($urandom_range(0, COLUMNS - 1)), pick_row());
      end
    end else if (kind < 83) begin
      clear_screen();
      read_cell(COL_W'($urandom_range(0, COLUMNS - 1)), pick_row());
    end else begin
      // noise over the whole range of every field
      repeat ($urandom_range(1, 8)) begin
        send_item(tcw_cmd_e'(CMD_W'($urandom_range(0, 3))), CHAR_W'($urandom_range(0, 255)),
                  COLOR_W'($urandom_range(0, 255)), COL_W'($urandom_range(0, 127)),
                  ROW_W'($urandom_range(0, 31)));
      end
    end
  endtask

  // Result side: calm stretches, choppy stalls, long stalls, one long hold-off
  initial begin : result_sink
    int mode;
    @(negedge clk);
    forever begin
      mode = int'($urandom_range(0, 99));
      if (hold_off_req && !hold_off_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_done = 1'b1;
      end else if (mode < 30) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(20, 200)) @(negedge clk);
      end else if (mode < 90) begin
        repeat ($urandom_range(10, 100)) begin
          out_stall <= ($urandom_range(0, 3) == 0);
          @(negedge clk);
        end
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(10, 60)) @(negedge clk);
      end
    end
  end

  // Item side: reset, directed checks, then random phases under several colors
  initial begin : stimulus
    logic [COLOR_W-1:0] phase_color [4];
    int                 phase_end;
    phase_color[0] = 8'hFF;
    phase_color[1] = COLOR_W'($urandom_range(0, 255));
    phase_color[2] = COLOR_W'($urandom_range(0, 255));
    phase_color[3] = COLOR_W'($urandom_range(0, 255));
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // hold off while the store is blanked after reset
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    write_color(8'h00);

    // directed: reset contents, edge bytes, control characters, corners, off screen
    read_cell(7'd0, 5'd0);
    read_cell(COL_W'(COLUMNS - 1), ROW_W'(ROWS - 1));
    type_char(8'h41);
    type_char(8'h00);
    type_char(8'hFF);
    read_cell(7'd0, 5'd0);
    type_char(CH_RETURN);
    type_char(CH_NEWLINE);
    put_cell(8'hFF, 8'hFF, COL_W'(COLUMNS - 1), ROW_W'(ROWS - 1));
    put_cell(CH_NEWLINE, 8'h00, 7'd0, 5'd0);
    put_cell(CH_RETURN, 8'hA5, 7'd1, 5'd0);
    put_cell(8'h55, 8'h55, COL_W'(COLUMNS), 5'd0);
    put_cell(8'hAA, 8'hAA, 7'd0, ROW_W'(ROWS));
    put_cell(8'hFF, 8'hFF, 7'h7F, 5'h1F);
    read_cell(COL_W'(COLUMNS - 1), ROW_W'(ROWS - 1));
    read_cell(7'd1, 5'd0);
    read_cell(COL_W'(COLUMNS), ROW_W'(ROWS - 1));
    read_cell(COL_W'(COLUMNS - 1), ROW_W'(ROWS));
    read_cell(7'h7F, 5'h1F);
    clear_screen();
    read_cell(7'd40, 5'd12);
    send_item(CMD_CLEAR, 8'hFF, 8'hFF, 7'h7F, 5'h1F);
    send_item(CMD_READ, 8'hFF, 8'hFF, 7'd0, 5'd0);

    for (int p = 0; p < 4; p++) begin
      drain();
      write_color(phase_color[p]);
      if (p == 1) begin
        hold_off_req = 1'b1;
      end
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) run_sequence();
    end

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
